FILE: rtl/core/distance_vector_route_update_core_macros.svh
// assertion macros shared by the route update core
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk_i, quiet during reset
`define DVRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, quiet during reset
`define DVRU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DVRU_ASSERT_IMP(label, ante, cons, msg)
`define DVRU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/dvru_pkg.sv
`timescale 1ns / 1ps

package dvru_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = IDX_W + 1;

  // field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned METRIC_W = 5;
  localparam int unsigned SLOT_W   = 6;

  // hop count that means unreachable
  localparam logic [METRIC_W-1:0] METRIC_INF = METRIC_W'(16);

  typedef enum logic [1:0] {
    ACT_UPDATED  = 2'd0,
    ACT_KEPT     = 2'd1,
    ACT_INSERTED = 2'd2,
    ACT_DROPPED  = 2'd3
  } action_e;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [ADDR_W-1:0]   mask;
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   next_hop;
  } route_t;

endpackage

FILE: rtl/core/dvru_if.sv
`timescale 1ns / 1ps

// advertised route channel
interface dvru_in_if;
  logic                             valid;
  logic                             ready;
  logic [dvru_pkg::ADDR_W-1:0]      prefix;
  logic [dvru_pkg::ADDR_W-1:0]      prefix_mask;
  logic [dvru_pkg::METRIC_W-1:0]    adv_metric;
  logic [dvru_pkg::ADDR_W-1:0]      sender;

  modport source (output valid, prefix, prefix_mask, adv_metric, sender, input ready);
  modport sink   (input valid, prefix, prefix_mask, adv_metric, sender, output ready);
endinterface

// update result channel
interface dvru_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [dvru_pkg::SLOT_W-1:0]      slot;
  logic [dvru_pkg::METRIC_W-1:0]    new_metric;

  modport source (output valid, action, slot, new_metric, input ready);
  modport sink   (input valid, action, slot, new_metric, output ready);
endinterface

FILE: rtl/core/dvru_route_ram.sv
`timescale 1ns / 1ps

// single port synchronous ram with a registered read port
module dvru_route_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/distance_vector_route_update_core.sv
`timescale 1ns / 1ps

// Distance-vector route table update.
// in_i carries one advertised route per transaction (prefix, prefix_mask,
// adv_metric, sender); out_o returns exactly one result per advertisement
// (action, slot, new_metric). Both use valid/ready.
// An advertisement is taken only while the core is idle. The core then walks
// all TABLE_ENTRIES slots of the route memory through its single port, one
// read per cycle, looking for the matching prefix/mask and the lowest free
// slot. The last read is checked in the cycle after it is issued, the walk
// then closes, and the decide step writes the route back and loads the
// result register. The next advertisement is taken only once the decide
// step is done and the core is idle again, never during a memory walk.
// The result register lets the next advertisement be accepted and scanned
// while a result still waits; if the receiver stalls, the core holds at the
// decide step until the register is free.
// Reset clears the entry valid flags, so the table starts empty at once; the
// route memory itself is not cleared and is read only through valid entries.
module distance_vector_route_update_core (
  input  logic clk_i,
  input  logic rst_ni,
  dvru_in_if.sink    in_i,
  dvru_out_if.source out_o
);
  import dvru_pkg::*;

  `include "distance_vector_route_update_core_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     rd_cnt_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [ADDR_W-1:0]    pfx_q;
  logic [ADDR_W-1:0]    msk_q;
  logic [METRIC_W-1:0]  metric_q;
  logic [ADDR_W-1:0]    sender_q;

  logic                 hit_found_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [METRIC_W-1:0]  hit_metric_q;
  logic [ADDR_W-1:0]    hit_hop_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;

  logic                 out_valid_q;
  action_e              out_action_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [METRIC_W-1:0]  out_metric_q;

  logic                 scan_rd;
  logic                 cmp_match;
  logic                 out_free;
  logic                 finish;
  logic                 do_update;
  logic                 do_insert;
  logic                 wr_en;
  logic [IDX_W-1:0]     mem_addr;
  route_t               wr_data;
  route_t               rd_data;
  logic [METRIC_W-1:0]  in_metric;

  // incremented hop count, saturated at unreachable
  assign in_metric = (in_i.adv_metric >= METRIC_INF) ? METRIC_INF
                                                     : in_i.adv_metric + METRIC_W'(1);

  // scan and decide control
  assign scan_rd   = (state_q == ST_SCAN) && (rd_cnt_q != CNT_W'(TABLE_ENTRIES));
  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] &&
                     (rd_data.prefix == pfx_q) && (rd_data.mask == msk_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign finish    = (state_q == ST_DONE) && out_free;
  assign do_update = hit_found_q && ((hit_hop_q == sender_q) || (hit_metric_q > metric_q));
  assign do_insert = !hit_found_q && free_found_q;
  assign wr_en     = finish && (do_update || do_insert);

  // single memory port: scan reads, decide step writes
  always_comb begin
    if (state_q == ST_DONE) begin
      mem_addr = hit_found_q ? hit_idx_q : free_idx_q;
    end else begin
      mem_addr = rd_cnt_q[IDX_W-1:0];
    end
  end

  assign wr_data = '{prefix: pfx_q, mask: msk_q, metric: metric_q, next_hop: sender_q};

  dvru_route_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH ($bits(route_t))
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (scan_rd),
    .addr_i  (mem_addr),
    .wdata_i (wr_data),
    .rdata_o (rd_data)
  );

  // sequencer, search state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      valid_q      <= '0;
      pfx_q        <= '0;
      msk_q        <= '0;
      metric_q     <= '0;
      sender_q     <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      hit_metric_q <= '0;
      hit_hop_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_action_q <= ACT_DROPPED;
      out_slot_q   <= '0;
      out_metric_q <= '0;
    end else begin
      // result loaded by the decide step or taken by the receiver
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            pfx_q        <= in_i.prefix;
            msk_q        <= in_i.prefix_mask;
            sender_q     <= in_i.sender;
            metric_q     <= in_metric;
            rd_cnt_q     <= '0;
            cmp_vld_q    <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // issue the next read
          cmp_vld_q <= scan_rd;
          if (scan_rd) begin
            cmp_idx_q <= rd_cnt_q[IDX_W-1:0];
            rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
          end
          // check the entry read last cycle
          if (cmp_vld_q) begin
            if (cmp_match && !hit_found_q) begin
              hit_found_q  <= 1'b1;
              hit_idx_q    <= cmp_idx_q;
              hit_metric_q <= rd_data.metric;
              hit_hop_q    <= rd_data.next_hop;
            end
            if (!valid_q[cmp_idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= cmp_idx_q;
            end
          end
          if (!scan_rd && !cmp_vld_q) begin
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_metric_q <= metric_q;
            priority if (hit_found_q) begin
              out_action_q <= do_update ? ACT_UPDATED : ACT_KEPT;
              out_slot_q   <= SLOT_W'(hit_idx_q);
            end else if (free_found_q) begin
              out_action_q        <= ACT_INSERTED;
              out_slot_q          <= SLOT_W'(free_idx_q);
              valid_q[free_idx_q] <= 1'b1;
            end else begin
              out_action_q <= ACT_DROPPED;
              out_slot_q   <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.action     = out_action_q;
  assign out_o.slot       = out_slot_q;
  assign out_o.new_metric = out_metric_q;

  // checks
  `DVRU_ASSERT_IMP(a_drop_only_when_full, out_o.valid && (out_o.action == ACT_DROPPED),
                   &valid_q, "drop reported with a free slot")
  `DVRU_ASSERT_NXT(a_insert_sets_valid, finish && do_insert,
                   valid_q[$past(free_idx_q)], "inserted slot not marked valid")
  `DVRU_ASSERT_IMP(a_scan_count_bound, state_q == ST_SCAN,
                   rd_cnt_q <= CNT_W'(TABLE_ENTRIES), "scan counter past table end")

endmodule

FILE: tb/sv/distance_vector_route_update_core_tb.sv
`timescale 1ns / 1ps

module distance_vector_route_update_core_tb;
  import dvru_pkg::*;

  // neighbor addresses used by the directed tests
  localparam logic [ADDR_W-1:0] NBR_A = 32'h0A00_0001;
  localparam logic [ADDR_W-1:0] NBR_B = 32'hC0A8_0102;
  localparam logic [ADDR_W-1:0] NBR_C = 32'hAC10_FF03;
  localparam logic [ADDR_W-1:0] NBR_D = 32'h5A5A_A5A5;
  localparam int unsigned SCAN_CYCLES = TABLE_ENTRIES + 3;

  typedef struct packed {
    action_e             action;
    logic [SLOT_W-1:0]   slot;
    logic [METRIC_W-1:0] metric;
  } route_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dvru_in_if  adv_if ();
  dvru_out_if res_if ();

  distance_vector_route_update_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (adv_if),
    .out_o  (res_if)
  );

  // shadow of the routing table
  logic                rt_valid    [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   rt_prefix   [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   rt_mask     [TABLE_ENTRIES];
  logic [METRIC_W-1:0] rt_metric   [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   rt_next_hop [TABLE_ENTRIES];
  int unsigned         rt_count;

  route_result_t route_expect_q[$];
  route_result_t route_expect;
  int unsigned   err_count;
  int unsigned   action_seen [4];
  int unsigned   idle_pct;
  int unsigned   stall_pct;

  // 12 ns clock
  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // compute the expected result of one advertisement and update the shadow table
  function automatic void predict_route_update(input logic [ADDR_W-1:0] pfx,
                                               input logic [ADDR_W-1:0] msk,
                                               input logic [METRIC_W-1:0] adv,
                                               input logic [ADDR_W-1:0] from);
    route_result_t res;
    int hit;
    int free_idx;
    hit      = -1;
    free_idx = -1;
    res.metric = (adv >= METRIC_INF - 1'b1) ? METRIC_INF : adv + 1'b1;
    res.action = ACT_DROPPED;
    res.slot   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (rt_valid[i]) begin
        if (hit < 0 && rt_prefix[i] == pfx && rt_mask[i] == msk) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      // same neighbor always wins, others only with a shorter path
      if (rt_next_hop[hit] == from || rt_metric[hit] > res.metric) begin
        rt_metric[hit]   = res.metric;
        rt_next_hop[hit] = from;
        res.action       = ACT_UPDATED;
      end else begin
        res.action = ACT_KEPT;
      end
      res.slot = SLOT_W'(hit);
    end else if (free_idx >= 0) begin
      rt_valid[free_idx]    = 1'b1;
      rt_prefix[free_idx]   = pfx;
      rt_mask[free_idx]     = msk;
      rt_metric[free_idx]   = res.metric;
      rt_next_hop[free_idx] = from;
      rt_count++;
      res.action = ACT_INSERTED;
      res.slot   = SLOT_W'(free_idx);
    end
    route_expect_q.push_back(res);
  endfunction

  // send one advertisement, with an optional idle gap before it
  task automatic send_route(input logic [ADDR_W-1:0] pfx, input logic [ADDR_W-1:0] msk,
                            input logic [METRIC_W-1:0] adv, input logic [ADDR_W-1:0] from);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      adv_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    adv_if.valid       <= 1'b1;
    adv_if.prefix      <= pfx;
    adv_if.prefix_mask <= msk;
    adv_if.adv_metric  <= adv;
    adv_if.sender      <= from;
    do @(posedge clk_i); while (!adv_if.ready);
    predict_route_update(pfx, msk, adv, from);
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_results_drained();
    adv_if.valid <= 1'b0;
    do @(posedge clk_i); while (route_expect_q.size() != 0);
  endtask

  // new routes at the metric extremes, including values above range
  task automatic test_metric_extremes();
    send_route(32'h0000_0000, 32'h0000_0000, 5'd0,  NBR_A);
    send_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_route(32'h0A01_0000, 32'hFFFF_0000, 5'd15, NBR_B);
    send_route(32'h0A02_0000, 32'hFFFF_0000, 5'd16, NBR_A);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd14, 32'h0000_0000);
  endtask

  // same prefix with another mask and a near prefix are distinct routes
  task automatic test_mask_distinct();
    send_route(32'h0A01_0000, 32'hFF00_0000, 5'd3, NBR_A);
    send_route(32'h0A01_0001, 32'hFFFF_0000, 5'd3, NBR_A);
    send_route(32'h0A01_0000, 32'hFFFF_0000, 5'd15, NBR_B);
  endtask

  // update and keep rules on a known route
  task automatic test_update_rules();
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd5,  NBR_B);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd5,  NBR_A);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd10, NBR_C);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd20, NBR_B);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd15, NBR_A);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd0,  NBR_A);
    send_route(32'h0A03_0000, 32'hFFFF_0000, 5'd31, NBR_A);
    send_route(32'h0000_0000, 32'h0000_0000, 5'd0,  NBR_B);
    send_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd7,  NBR_D);
  endtask

  // one random advertisement: mostly known routes, some new ones
  task automatic send_random_route();
    logic [ADDR_W-1:0]   pfx;
    logic [ADDR_W-1:0]   msk;
    logic [METRIC_W-1:0] adv;
    logic [ADDR_W-1:0]   from;
    int unsigned         idx;
    int unsigned         pick;
    pick = $urandom_range(99);
    adv  = ($urandom_range(9) == 0) ? METRIC_W'($urandom_range(31, 16))
                                    : METRIC_W'($urandom_range(15));
    case ($urandom_range(3))
      0: from = NBR_A;
      1: from = NBR_B;
      2: from = NBR_C;
      default: from = $urandom;
    endcase
    if (rt_count > 0 && pick < 70) begin
      idx = $urandom_range(rt_count - 1);
      pfx = rt_prefix[idx];
      msk = rt_mask[idx];
      if ($urandom_range(1) == 0) from = rt_next_hop[idx];
    end else begin
      pfx = $urandom;
      msk = ($urandom_range(1) == 0) ? ADDR_W'($urandom)
                                     : 32'hFFFF_FFFF << $urandom_range(32);
      // same prefix under a different mask now and then
      if (rt_count > 0 && pick < 80) pfx = rt_prefix[$urandom_range(rt_count - 1)];
    end
    send_route(pfx, msk, adv, from);
  endtask

  // random traffic under one idling and stall setting
  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned n_items);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n_items) send_random_route();
    wait_results_drained();
  endtask

  // fill every slot, then unknown routes must be dropped and known ones still match
  task automatic test_table_full();
    int unsigned idx;
    idle_pct  = 20;
    stall_pct = 20;
    while (rt_count < TABLE_ENTRIES) begin
      send_route($urandom, $urandom, METRIC_W'($urandom), $urandom);
    end
    send_route(32'h0000_0001, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
    send_route(32'hFFFF_FFFE, 32'hFFFF_FFFF, 5'd0,  32'h0000_0000);
    send_route(32'h8000_0000, 32'h8000_0000, 5'd16, NBR_A);
    repeat (12) begin
      send_route($urandom, $urandom, METRIC_W'($urandom), $urandom);
      idx = $urandom_range(TABLE_ENTRIES - 1);
      send_route(rt_prefix[idx], rt_mask[idx], METRIC_W'($urandom), rt_next_hop[idx]);
    end
    wait_results_drained();
  endtask

  // result receiver with random backpressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // mismatch report
  task automatic report_field(input string field, input int unsigned exp_val,
                              input logic [7:0] act_val);
    err_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (route_expect_q.size() == 0) begin
        err_count++;
        $display("%0t ns: result with nothing expected, action %0d slot %0d metric %0d",
                 $time, res_if.action, res_if.slot, res_if.new_metric);
      end else begin
        route_expect = route_expect_q.pop_front();
        action_seen[route_expect.action]++;
        if (res_if.action !== route_expect.action)
          report_field("action", route_expect.action, 8'(res_if.action));
        if (res_if.slot !== route_expect.slot)
          report_field("slot", route_expect.slot, 8'(res_if.slot));
        if (res_if.new_metric !== route_expect.metric)
          report_field("new_metric", route_expect.metric, 8'(res_if.new_metric));
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    err_count = 0;
    rt_count  = 0;
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) rt_valid[i] = 1'b0;
    for (int i = 0; i < 4; i++) action_seen[i] = 0;
    rst_ni             <= 1'b0;
    adv_if.valid       <= 1'b0;
    adv_if.prefix      <= '0;
    adv_if.prefix_mask <= '0;
    adv_if.adv_metric  <= '0;
    adv_if.sender      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_metric_extremes();
    test_mask_distinct();
    test_update_rules();
    wait_results_drained();

    test_random_phase(0,  0,  100);
    test_random_phase(54, 0,  100);
    test_random_phase(0,  54, 100);
    test_random_phase(20, 20, 100);
    test_table_full();

    // quiet tail: no stray results may appear
    repeat (2 * SCAN_CYCLES) @(posedge clk_i);

    $display("advertisements checked: %0d updated, %0d kept, %0d inserted, %0d dropped",
             action_seen[ACT_UPDATED], action_seen[ACT_KEPT],
             action_seen[ACT_INSERTED], action_seen[ACT_DROPPED]);
    $display("table filled to %0d of %0d slots across four idling phases, %0d errors",
             rt_count, TABLE_ENTRIES, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dvru_pkg.sv
rtl/core/dvru_if.sv
rtl/core/dvru_route_ram.sv
rtl/core/distance_vector_route_update_core.sv
tb/sv/distance_vector_route_update_core_tb.sv
